// ===== rtl/wots_pkg.sv =====
// WOTS+ chain package: SHA-256 constants, round helpers and sequencer types.
// Used by wots_sha_core and wots_plus_chain_sha256.
package wots_pkg;

    localparam int unsigned WINTERNITZ_W = 16;
    localparam int unsigned STEP_W       = 4;
    localparam logic [7:0]  DOM_F        = 8'd0;
    localparam logic [7:0]  DOM_PRF      = 8'd3;

    // first position past the chain end, at step counter width
    localparam logic [STEP_W:0] CHAIN_END = WINTERNITZ_W[STEP_W:0];

    localparam logic [1:0] REG_SEED0 = 2'd0;
    localparam logic [1:0] REG_SEED1 = 2'd1;
    localparam logic [1:0] REG_SEED2 = 2'd2;
    localparam logic [1:0] REG_SEED3 = 2'd3;

    localparam logic [255:0] SHA_IV = {
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};

    // Hash job kinds, in the order they run within one chain step.
    typedef enum logic [1:0] {
        JOB_KEY  = 2'd0,
        JOB_MASK = 2'd1,
        JOB_F    = 2'd2
    } job_t;

    function automatic logic [31:0] round_k(input logic [5:0] t);
        logic [31:0] k;
        unique case (t)
            6'd0:  k = 32'h428a2f98; 6'd1:  k = 32'h71374491;
            6'd2:  k = 32'hb5c0fbcf; 6'd3:  k = 32'he9b5dba5;
            6'd4:  k = 32'h3956c25b; 6'd5:  k = 32'h59f111f1;
            6'd6:  k = 32'h923f82a4; 6'd7:  k = 32'hab1c5ed5;
            6'd8:  k = 32'hd807aa98; 6'd9:  k = 32'h12835b01;
            6'd10: k = 32'h243185be; 6'd11: k = 32'h550c7dc3;
            6'd12: k = 32'h72be5d74; 6'd13: k = 32'h80deb1fe;
            6'd14: k = 32'h9bdc06a7; 6'd15: k = 32'hc19bf174;
            6'd16: k = 32'he49b69c1; 6'd17: k = 32'hefbe4786;
            6'd18: k = 32'h0fc19dc6; 6'd19: k = 32'h240ca1cc;
            6'd20: k = 32'h2de92c6f; 6'd21: k = 32'h4a7484aa;
            6'd22: k = 32'h5cb0a9dc; 6'd23: k = 32'h76f988da;
            6'd24: k = 32'h983e5152; 6'd25: k = 32'ha831c66d;
            6'd26: k = 32'hb00327c8; 6'd27: k = 32'hbf597fc7;
            6'd28: k = 32'hc6e00bf3; 6'd29: k = 32'hd5a79147;
            6'd30: k = 32'h06ca6351; 6'd31: k = 32'h14292967;
            6'd32: k = 32'h27b70a85; 6'd33: k = 32'h2e1b2138;
            6'd34: k = 32'h4d2c6dfc; 6'd35: k = 32'h53380d13;
            6'd36: k = 32'h650a7354; 6'd37: k = 32'h766a0abb;
            6'd38: k = 32'h81c2c92e; 6'd39: k = 32'h92722c85;
            6'd40: k = 32'ha2bfe8a1; 6'd41: k = 32'ha81a664b;
            6'd42: k = 32'hc24b8b70; 6'd43: k = 32'hc76c51a3;
            6'd44: k = 32'hd192e819; 6'd45: k = 32'hd6990624;
            6'd46: k = 32'hf40e3585; 6'd47: k = 32'h106aa070;
            6'd48: k = 32'h19a4c116; 6'd49: k = 32'h1e376c08;
            6'd50: k = 32'h2748774c; 6'd51: k = 32'h34b0bcb5;
            6'd52: k = 32'h391c0cb3; 6'd53: k = 32'h4ed8aa4a;
            6'd54: k = 32'h5b9cca4f; 6'd55: k = 32'h682e6ff3;
            6'd56: k = 32'h748f82ee; 6'd57: k = 32'h78a5636f;
            6'd58: k = 32'h84c87814; 6'd59: k = 32'h8cc70208;
            6'd60: k = 32'h90befffa; 6'd61: k = 32'ha4506ceb;
            6'd62: k = 32'hbef9a3f7; 6'd63: k = 32'hc67178f2;
            default: k = 32'h0;
        endcase
        return k;
    endfunction

    function automatic logic [31:0] ror(input logic [31:0] x, input int unsigned n);
        return (x >> n) | (x << (32 - n));
    endfunction

endpackage

// ===== rtl/wots_sha_core.sv =====
// SHA-256 compression core: one round per cycle, 64 rounds per block.
// Depends on wots_pkg.
module wots_sha_core
    import wots_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         start,      // begin a block; state_in/block sampled
    input  logic [255:0] state_in,
    input  logic [511:0] block,      // big-endian, word 0 in the top bits
    output logic         done,       // one-cycle pulse, state_out valid
    output logic [255:0] state_out
);

    logic [511:0] w_reg, w_next;
    logic [255:0] v_reg, v_next;
    logic [255:0] h_reg, h_next;
    logic [5:0]   t_reg, t_next;
    logic         busy_reg, busy_next;
    logic         done_reg, done_next;

    logic [31:0] a, b, c, d, e, f, g, hh, wt, t1, t2, s0, s1, wn, w1, w14;

    always_comb
    begin
        {a, b, c, d, e, f, g, hh} = v_reg;
        wt  = w_reg[511:480];
        w1  = w_reg[479:448];
        w14 = w_reg[63:32];
        s0  = ror(w1, 7) ^ ror(w1, 18) ^ (w1 >> 3);
        s1  = ror(w14, 17) ^ ror(w14, 19) ^ (w14 >> 10);
        wn  = wt + s0 + w_reg[223:192] + s1;
        t1  = hh + (ror(e, 6) ^ ror(e, 11) ^ ror(e, 25)) + ((e & f) ^ (~e & g))
            + round_k(t_reg) + wt;
        t2  = (ror(a, 2) ^ ror(a, 13) ^ ror(a, 22)) + ((a & b) ^ (a & c) ^ (b & c));

        w_next    = w_reg;
        v_next    = v_reg;
        h_next    = h_reg;
        t_next    = t_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            w_next    = block;
            v_next    = state_in;
            h_next    = state_in;
            t_next    = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            w_next = {w_reg[479:0], wn};
            v_next = {t1 + t2, a, b, c, d + t1, e, f, g};
            t_next = t_reg + 6'd1;
            if (t_reg == 6'd63)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            t_reg    <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            t_reg    <= t_next;
        end
    end

    always_ff @(posedge clk)
    begin
        w_reg <= w_next;
        v_reg <= v_next;
        h_reg <= h_next;
    end

    genvar i;
    for (i = 0; i < 8; i++)
    begin : g_fin
        assign state_out[32*i +: 32] = h_reg[32*i +: 32] + v_reg[32*i +: 32];
    end
    assign done = done_reg;

    a_no_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start |-> !busy_reg) else $error("core started while busy");
    a_done_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        (busy_reg && t_reg == 6'd63 && !start) |=> done_reg)
        else $error("no done after last round");
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> !busy_reg) else $error("done while busy");

endmodule

// ===== rtl/wots_plus_chain_sha256.sv =====
// WOTS+ chain walker over SHA-256 (one shared compression core).
// Each of the n = min(step_count, 16 - start_step) steps passes ST_CHECK, then runs
// three two-block hashes; each block is a core start plus 64 rounds. One item at a
// time: s_axis_tready is low from acceptance until the result has been taken.
// Reset (rst_n, async active low) clears control and zeroes the seed.
module wots_plus_chain_sha256
    import wots_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    // seed registers
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [1:0]   cfg_index,
    input  logic [63:0]  cfg_data,
    // input: in_word0..3 [255:0], start_step [259:256], step_count [263:260],
    // OTS index [279:264], chain_index [286:280], zero pad [287]
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [287:0] s_axis_tdata,
    // output: out_word0..3 from the lowest bit up
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [255:0] m_axis_tdata
);

    typedef enum logic [4:0] {
        ST_IDLE  = 5'b00001,
        ST_CHECK = 5'b00010,
        ST_BLK0  = 5'b00100,
        ST_BLK1  = 5'b01000,
        ST_OUT   = 5'b10000
    } state_t;

    state_t         state_reg, state_next;
    job_t           job_reg, job_next;
    logic [255:0]   seed_reg;
    logic [255:0]   val_reg, val_next;
    logic [255:0]   key_reg, key_next;
    logic [255:0]   mask_reg, mask_next;
    logic [STEP_W:0] j_reg, j_next;     // holds 16 at chain end
    logic [STEP_W:0] end_reg, end_next;
    logic [15:0]    ots_reg, ots_next;
    logic [6:0]     chn_reg, chn_next;

    logic         core_start, core_done;
    logic [255:0] core_state_in, core_out;
    logic [511:0] core_block;
    logic [255:0] adrs, msg_k, msg_m;
    logic [4:0]   sum;

    // byte order: seed_word0 is bytes 0-7, so it sits on top of the key field of the big-endian block
    function automatic logic [255:0] be256(input logic [255:0] w);
        return {w[63:0], w[127:64], w[191:128], w[255:192]};
    endfunction

    assign cfg_ready     = 1'b1;
    assign s_axis_tready = (state_reg == ST_IDLE);
    assign m_axis_tvalid = (state_reg == ST_OUT);
    assign m_axis_tdata  = be256(val_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            seed_reg <= '0;
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_SEED0: seed_reg[255:192] <= cfg_data;
                REG_SEED1: seed_reg[191:128] <= cfg_data;
                REG_SEED2: seed_reg[127:64]  <= cfg_data;
                REG_SEED3: seed_reg[63:0]    <= cfg_data;
                default:   seed_reg <= seed_reg;
            endcase
        end
    end

    // address: words 0-3 zero, ots, chain, step, keyAndMask
    assign adrs  = {128'd0, 16'd0, ots_reg, 25'd0, chn_reg, 27'd0, j_reg,
                    31'd0, (job_reg == JOB_MASK)};
    // first block is loaded as the job starts, so it follows the job being launched
    assign msg_k = (job_next == JOB_F) ? key_reg : seed_reg;
    assign msg_m = (job_reg == JOB_F) ? (val_reg ^ mask_reg) : adrs;

    // a start from ST_BLK0 launches the second block of the running hash
    always_comb
    begin
        core_block    = {248'd0, (job_next == JOB_F) ? DOM_F : DOM_PRF, msg_k};
        core_state_in = SHA_IV;
        if (state_reg == ST_BLK0)
        begin
            core_block    = {msg_m, 8'h80, 214'd0, 34'h300};
            core_state_in = core_out;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        job_next   = job_reg;
        val_next   = val_reg;
        key_next   = key_reg;
        mask_next  = mask_reg;
        j_next     = j_reg;
        end_next   = end_reg;
        ots_next   = ots_reg;
        chn_next   = chn_reg;
        core_start = 1'b0;
        sum        = {1'b0, s_axis_tdata[259:256]} + {1'b0, s_axis_tdata[263:260]};
        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_axis_tvalid)
                begin
                    val_next   = be256(s_axis_tdata[255:0]);
                    j_next     = {1'b0, s_axis_tdata[259:256]};
                    end_next   = (sum > CHAIN_END) ? CHAIN_END : sum;
                    ots_next   = s_axis_tdata[279:264];
                    chn_next   = s_axis_tdata[286:280];
                    job_next   = JOB_KEY;
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK:
            begin
                if (j_reg < end_reg)
                begin
                    core_start = 1'b1;
                    state_next = ST_BLK0;
                end
                else
                    state_next = ST_OUT;
            end
            ST_BLK0:
            begin
                if (core_done)
                begin
                    core_start = 1'b1;
                    state_next = ST_BLK1;
                end
            end
            ST_BLK1:
            begin
                if (core_done)
                begin
                    unique case (job_reg)
                        JOB_KEY:
                        begin
                            key_next   = core_out;
                            job_next   = JOB_MASK;
                            core_start = 1'b1;
                            state_next = ST_BLK0;
                        end
                        JOB_MASK:
                        begin
                            mask_next  = core_out;
                            job_next   = JOB_F;
                            core_start = 1'b1;
                            state_next = ST_BLK0;
                        end
                        default:
                        begin
                            val_next   = core_out;
                            job_next   = JOB_KEY;
                            j_next     = j_reg + 5'd1;
                            state_next = ST_CHECK;
                        end
                    endcase
                end
            end
            ST_OUT:
            begin
                if (m_axis_tready)
                    state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            job_reg   <= JOB_KEY;
            j_reg     <= '0;
            end_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            job_reg   <= job_next;
            j_reg     <= j_next;
            end_reg   <= end_next;
        end
    end

    always_ff @(posedge clk)
    begin
        val_reg  <= val_next;
        key_reg  <= key_next;
        mask_reg <= mask_next;
        ots_reg  <= ots_next;
        chn_reg  <= chn_next;
    end

    wots_sha_core u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (core_start),
        .state_in  (core_state_in),
        .block     (core_block),
        .done      (core_done),
        .state_out (core_out)
    );

    a_step_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_IDLE) |-> (j_reg <= CHAIN_END && end_reg <= CHAIN_END))
        else $error("step counter beyond chain end");
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> $stable(val_reg))
        else $error("result changed while stalled");
    a_core_done_busy: assert property (@(posedge clk) disable iff (!rst_n)
        core_done |-> (state_reg == ST_BLK0 || state_reg == ST_BLK1))
        else $error("core finished outside a hash");

endmodule
